// ===== src/dota_pkg.sv =====
// ---------------------------------------------------------------------------
// dota_pkg: shared types and constants of the daily on-time accumulator
// command codes, controller states, control/status bundles and field widths
// ---------------------------------------------------------------------------
package dota_pkg;

  // field widths
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAY_W   = 16;
  localparam int unsigned SEC_W   = 17;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned TOTAL_W = 25;
  localparam int unsigned HOURS_W = 21;

  localparam int unsigned BUCKETS_DEF = 8;

  // seconds in a day
  localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;

  // day number: 86400 = 675 * 2^7, day = ((t >> 7) * ceil(2^35 / 675)) >> 35
  localparam int unsigned          DAY_LO_W  = 7;
  localparam int unsigned          DAY_HI_W  = EPOCH_W - DAY_LO_W;
  localparam int unsigned          DAY_ODD_W = 10;
  localparam logic [DAY_ODD_W-1:0] DAY_ODD   = 10'd675;
  localparam int unsigned          DAY_RCP_W = 26;
  localparam logic [DAY_RCP_W-1:0] DAY_RCP   = 26'd50903317;
  localparam int unsigned          DAY_SHIFT = 35;

  // q8 hours: x*256/3600 = (x*16)/225 = ((x*16) * ceil(2^37 / 225)) >> 37
  localparam int unsigned           HDIV_W     = TOTAL_W + 4;
  localparam int unsigned           HOUR_RCP_W = 30;
  localparam logic [HOUR_RCP_W-1:0] HOUR_RCP   = 30'd610839794;
  localparam int unsigned           HOUR_SHIFT = 37;

  // steps after the load cycle: back product, then offset into the day
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_DIV,
    ST_CHUNK,
    ST_RD,
    ST_EV,
    ST_NEXT,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic start;
    logic div_load;
    logic div_step;
    logic chunk;
    logic scan_rd;
    logic scan_ev;
    logic next_chunk;
    logic load_result;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic acc_needed;
    logic div_last;
    logic scan_last;
    logic scan_hit;
    logic last_chunk;
  } dp_stat_t;

endpackage

// ===== src/daily_on_time_accumulator.sv =====
// ---------------------------------------------------------------------------
// daily_on_time_accumulator: per-day switch on-time buckets with range query
// stream in commands, stream out one result word per command
// ---------------------------------------------------------------------------
// Keeps BUCKETS buckets of (day number, on-seconds), all day 0 / 0 s after
// reset. A begin word clears the on flag and records the epoch. A switch word
// adds the time since the recorded epoch (only if the switch was on and time
// moved forward) split at day boundaries of 86400 s, then records the new
// state and epoch; a chunk goes to the first bucket holding its day, else the
// first bucket with the smallest day is taken over and cleared. A query word
// sums the days query_day down to query_day-days_count+1 (not below day 0)
// and returns seconds plus hours in q8, floored. Non-query words return zero.
// One word is worked on at a time; the input takes the next word while a
// result still waits on the output, and the finish step of that next word
// waits until the earlier result is taken. Begin and unknown commands and a
// switch without accumulation go straight to the finish step. A query scans
// every bucket, then runs the reciprocal multiply for hours. A switch with
// accumulation runs the reciprocal multiply for day number and day offset,
// then for each day the interval touches scans the buckets (at least one, at
// most BUCKETS) until a match or the end. Each bucket takes a read step in the
// ram with registered read, then an evaluation step.
// ---------------------------------------------------------------------------
module daily_on_time_accumulator import dota_pkg::*; #(
  parameter int unsigned BUCKETS = BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // switch_on, now_epoch[31:0], query_day[15:0],
                                     // days_count[7:0], zero fill
  input  logic [1:0]  s_axis_tuser,  // command
  // result word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // total_seconds[24:0], hours_q8[20:0], zero fill
);

  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  logic [TOTAL_W-1:0] total_seconds;
  logic [HOURS_W-1:0] hours_q8;

  // sequencer: handshakes and step order
  dota_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // datapath: fields unpacked from the input word, lowest bit first
  dota_datapath #(
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .command_i       (s_axis_tuser),
    .switch_on_i     (s_axis_tdata[0]),
    .now_epoch_i     (s_axis_tdata[32:1]),
    .query_day_i     (s_axis_tdata[48:33]),
    .days_count_i    (s_axis_tdata[56:49]),
    .total_seconds_o (total_seconds),
    .hours_q8_o      (hours_q8)
  );

  // result word, held by the datapath result register until taken
  assign m_axis_tdata = {2'b00, hours_q8, total_seconds};

endmodule

// ===== src/dota_ram.sv =====
// ---------------------------------------------------------------------------
// dota_ram: generic single write, single read ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module dota_ram #(
  parameter  int unsigned WIDTH = 33,
  parameter  int unsigned DEPTH = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dota_datapath.sv =====
// ---------------------------------------------------------------------------
// dota_datapath: timeline registers, bucket ram, divider and result register
// executes the commands of the controller one step at a time
// ---------------------------------------------------------------------------
module dota_datapath import dota_pkg::*; #(
  parameter int unsigned BUCKETS = BUCKETS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic [1:0]         command_i,
  input  logic               switch_on_i,
  input  logic [EPOCH_W-1:0] now_epoch_i,
  input  logic [DAY_W-1:0]   query_day_i,
  input  logic [CNT_W-1:0]   days_count_i,
  output logic [TOTAL_W-1:0] total_seconds_o,
  output logic [HOURS_W-1:0] hours_q8_o
);

  localparam int unsigned AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = DAY_W + SEC_W;

  // latched item
  cmd_e               cmd_q;
  logic               on_q;
  logic [EPOCH_W-1:0] now_q;
  logic [DAY_W-1:0]   qday_q;
  logic [CNT_W-1:0]   count_q;

  // timeline state
  logic               was_on_q;
  logic [EPOCH_W-1:0] last_time_q;
  logic [BUCKETS-1:0] valid_q;

  // interval walk
  logic [EPOCH_W-1:0] remain_q;
  logic [DAY_W-1:0]   day_q;
  logic [SEC_W-1:0]   off_q;
  logic [SEC_W-1:0]   chunk_q;

  // bucket scan
  logic [AW-1:0]      addr_q;
  logic [AW-1:0]      pick_q;
  logic [DAY_W-1:0]   min_day_q;
  logic [TOTAL_W-1:0] total_q;

  // constant dividers
  logic [HOURS_W-1:0]  quo_hours_q;
  logic [DAY_HI_W-1:0] back_q;
  logic [DIV_CW-1:0]   div_cnt_q;

  // result register
  logic [TOTAL_W-1:0] res_total_q;
  logic [HOURS_W-1:0] res_hours_q;

  logic [DAY_HI_W+DAY_RCP_W-1:0] day_prod;
  logic [HDIV_W+HOUR_RCP_W-1:0]  hour_prod;
  logic [DAY_W+DAY_ODD_W-1:0]    back_full;
  logic [DAY_HI_W-1:0]           hi_rem;
  logic                          div_last;
  logic [SEC_W-1:0]   span;
  logic [SEC_W-1:0]   chunk_d;
  logic [EW-1:0]      rd_data;
  logic [DAY_W-1:0]   e_day;
  logic [SEC_W-1:0]   e_sec;
  logic               hit;
  logic               scan_last;
  logic [AW-1:0]      pick_d;
  logic [DAY_W-1:0]   min_day_d;
  logic [SEC_W:0]     sum;
  logic [SEC_W-1:0]   sat_sec;
  logic [DAY_W-1:0]   q_diff;
  logic               in_win;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;

  // day number and q8 hours by reciprocal multiplication, exact over the operand ranges
  assign day_prod  = {{DAY_RCP_W{1'b0}}, last_time_q[EPOCH_W-1:DAY_LO_W]}
                   * {{DAY_HI_W{1'b0}}, DAY_RCP};
  assign hour_prod = {{HOUR_RCP_W{1'b0}}, total_q, 4'b0000} * {{HDIV_W{1'b0}}, HOUR_RCP};

  // offset into the day: (t >> 7) - 675 * day, low 7 bits passed through
  assign back_full = {{DAY_ODD_W{1'b0}}, day_q} * {{DAY_W{1'b0}}, DAY_ODD};
  assign hi_rem    = last_time_q[EPOCH_W-1:DAY_LO_W] - back_q;
  assign div_last  = (div_cnt_q == DIV_CW'(DIV_STEPS - 1));

  // chunk up to the next day boundary
  assign span    = DAY_SECONDS - off_q;
  assign chunk_d = (remain_q < {{(EPOCH_W-SEC_W){1'b0}}, span}) ? remain_q[SEC_W-1:0] : span;

  // entry under the scan pointer, never-written entries read as day 0, 0 s
  assign e_day = valid_q[addr_q] ? rd_data[EW-1:SEC_W] : '0;
  assign e_sec = valid_q[addr_q] ? rd_data[SEC_W-1:0] : '0;

  assign hit       = (e_day == day_q);
  assign scan_last = (addr_q == AW'(BUCKETS - 1));

  // first entry with the smallest day
  always_comb begin
    pick_d    = pick_q;
    min_day_d = min_day_q;
    if (e_day < min_day_q) begin
      pick_d    = addr_q;
      min_day_d = e_day;
    end
  end

  assign sum     = {1'b0, e_sec} + {1'b0, chunk_q};
  assign sat_sec = (sum > {1'b0, DAY_SECONDS}) ? DAY_SECONDS : sum[SEC_W-1:0];

  // query window: qday - count < day <= qday, never below day 0
  assign q_diff = qday_q - e_day;
  assign in_win = (e_day <= qday_q) && (q_diff < {{(DAY_W-CNT_W){1'b0}}, count_q});

  assign ram_we    = cmd_i.scan_ev && (cmd_q == CMD_SWITCH) && (hit || scan_last);
  assign ram_waddr = hit ? addr_q : pick_d;
  assign ram_wdata = hit ? {day_q, sat_sec} : {day_q, chunk_q};

  dota_ram #(
    .WIDTH (EW),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_on_q    <= 1'b0;
      last_time_q <= '0;
      valid_q     <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CW'(1);
      end
      if (cmd_i.load_result) begin
        if (cmd_q == CMD_BEGIN) begin
          was_on_q    <= 1'b0;
          last_time_q <= now_q;
        end else if (cmd_q == CMD_SWITCH) begin
          was_on_q    <= on_q;
          last_time_q <= now_q;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= cmd_e'(command_i);
      on_q    <= switch_on_i;
      now_q   <= now_epoch_i;
      qday_q  <= query_day_i;
      count_q <= days_count_i;
    end
    if (cmd_i.start) begin
      total_q <= '0;
      addr_q  <= '0;
    end
    if (cmd_i.div_load) begin
      remain_q    <= now_q - last_time_q;
      day_q       <= day_prod[DAY_SHIFT +: DAY_W];
      quo_hours_q <= hour_prod[HOUR_SHIFT +: HOURS_W];
    end
    if (cmd_i.div_step) begin
      if (div_last) begin
        off_q <= {hi_rem[SEC_W-DAY_LO_W-1:0], last_time_q[DAY_LO_W-1:0]};
      end else begin
        back_q <= back_full[DAY_HI_W-1:0];
      end
    end
    if (cmd_i.chunk) begin
      chunk_q   <= chunk_d;
      addr_q    <= '0;
      pick_q    <= '0;
      min_day_q <= '1;
    end
    if (cmd_i.scan_ev) begin
      addr_q    <= addr_q + AW'(1);
      pick_q    <= pick_d;
      min_day_q <= min_day_d;
      if ((cmd_q == CMD_QUERY) && in_win) begin
        total_q <= total_q + {{(TOTAL_W-SEC_W){1'b0}}, e_sec};
      end
    end
    if (cmd_i.next_chunk) begin
      remain_q <= remain_q - {{(EPOCH_W-SEC_W){1'b0}}, chunk_q};
      day_q    <= day_q + DAY_W'(1);
      off_q    <= '0;
    end
    if (cmd_i.load_result) begin
      res_total_q <= (cmd_q == CMD_QUERY) ? total_q : '0;
      res_hours_q <= (cmd_q == CMD_QUERY) ? quo_hours_q : '0;
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.acc_needed = was_on_q && (now_q > last_time_q);
  assign stat_o.div_last   = div_last;
  assign stat_o.scan_last  = scan_last;
  assign stat_o.scan_hit   = hit;
  assign stat_o.last_chunk = (remain_q == {{(EPOCH_W-SEC_W){1'b0}}, chunk_q});

  assign total_seconds_o = res_total_q;
  assign hours_q8_o      = res_hours_q;

  // a chunk is never empty and never longer than a day
  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_ev && (cmd_q == CMD_SWITCH)) |-> ((chunk_q != '0) && (chunk_q <= DAY_SECONDS)))
    else $error("chunk out of range");

  // the interval walk never consumes more than what is left
  a_remain_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next_chunk |-> (remain_q >= {{(EPOCH_W-SEC_W){1'b0}}, chunk_q}))
    else $error("interval walk underflow");

  // bucket seconds stay saturated at one day
  a_bucket_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata[SEC_W-1:0] <= DAY_SECONDS))
    else $error("bucket seconds above one day");

endmodule

// ===== src/dota_ctrl.sv =====
// ---------------------------------------------------------------------------
// dota_ctrl: sequencing state machine of the daily on-time accumulator
// steps the datapath through divide, interval walk and bucket scans
// ---------------------------------------------------------------------------
module dota_ctrl import dota_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        case (stat_i.cmd)
          CMD_QUERY:  state_d = ST_RD;
          CMD_SWITCH: state_d = stat_i.acc_needed ? ST_LOAD : ST_FINISH;
          default:    state_d = ST_FINISH;
        endcase
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = (stat_i.cmd == CMD_QUERY) ? ST_FINISH : ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        cmd_o.chunk = 1'b1;
        state_d     = ST_RD;
      end
      ST_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_EV;
      end
      ST_EV: begin
        cmd_o.scan_ev = 1'b1;
        if (stat_i.cmd == CMD_QUERY) begin
          state_d = stat_i.scan_last ? ST_LOAD : ST_RD;
        end else begin
          state_d = (stat_i.scan_hit || stat_i.scan_last) ? ST_NEXT : ST_RD;
        end
      end
      ST_NEXT: begin
        cmd_o.next_chunk = 1'b1;
        state_d          = stat_i.last_chunk ? ST_FINISH : ST_CHUNK;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // a result appears only when the finish step loads it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result without finish step");

  // every evaluation follows its ram read
  a_read_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EV) |-> $past(state_q == ST_RD))
    else $error("scan evaluated without read");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_result && out_valid_q) |-> out_ready_i)
    else $error("pending result overwritten");

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the daily on-time accumulator
// ---------------------------------------------------------------------------
// Command words go in on the input stream and each one is scored against an
// independent model of the per-day bucket table, kept in a small scoreboard
// class. A directed opening covers field extremes, all commands, bucket
// takeover, backward and frozen time, bucket saturation, the top epoch day
// and queries that run below day zero. Random traffic follows in three
// throttling phases. Most of it is time-ordered switch and query traffic, and
// the rest is begin words, queries of random days, unknown commands and out-of-order epochs.
// ---------------------------------------------------------------------------
import dota_pkg::*;

typedef struct packed {
  logic [24:0] total_seconds;
  logic [20:0] hours_q8;
} on_time_result_t;

class on_time_scoreboard;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SLOTS        = BUCKETS_DEF;

  // model of the block state
  bit               on_flag;
  bit [31:0]        prev_epoch;
  bit [15:0]        day_tag  [SLOTS];
  int unsigned      day_secs [SLOTS];

  on_time_result_t  due_totals [$];
  int unsigned      fails;

  function new();
    on_flag    = 1'b0;
    prev_epoch = '0;
    fails      = 0;
    for (int j = 0; j < SLOTS; j++) begin
      day_tag[j]  = '0;
      day_secs[j] = 0;
    end
  endfunction

  // update the table for an accepted word and queue the result it owes
  function void note_command(cmd_e cmd, bit on, bit [31:0] epoch, bit [15:0] qday,
                             bit [7:0] count);
    on_time_result_t  res;
    bit [31:0]        start;
    bit [31:0]        day;
    bit [31:0]        chunk_end;
    longint unsigned  day_end;
    int unsigned      slot;
    int unsigned      pick;
    int unsigned      sum;
    int unsigned      total;
    bit               hit;
    total = 0;
    case (cmd)
      CMD_BEGIN: begin
        on_flag    = 1'b0;
        prev_epoch = epoch;
      end
      CMD_SWITCH: begin
        if (on_flag && epoch > prev_epoch) begin
          start = prev_epoch;
          while (start < epoch) begin
            day       = start / SECS_PER_DAY;
            day_end   = (64'(day) + 1) * SECS_PER_DAY;
            chunk_end = (64'(epoch) < day_end) ? epoch : day_end[31:0];
            // first bucket holding the day, else the first one with the oldest day
            hit  = 1'b0;
            slot = 0;
            pick = 0;
            for (int j = 0; j < SLOTS; j++) begin
              if (!hit) begin
                if (day_tag[j] == day[15:0]) begin
                  hit  = 1'b1;
                  slot = j;
                end else if (day_tag[j] < day_tag[pick]) begin
                  pick = j;
                end
              end
            end
            if (!hit) begin
              day_tag[pick]  = day[15:0];
              day_secs[pick] = 0;
              slot           = pick;
            end
            sum            = day_secs[slot] + (chunk_end - start);
            day_secs[slot] = (sum > SECS_PER_DAY) ? SECS_PER_DAY : sum;
            start          = chunk_end;
          end
        end
        on_flag    = on;
        prev_epoch = epoch;
      end
      CMD_QUERY: begin
        for (int i = 0; i < int'(count); i++) begin
          if (int'(qday) < i) break;
          hit = 1'b0;
          for (int j = 0; j < SLOTS; j++) begin
            if (!hit && int'(day_tag[j]) == int'(qday) - i) begin
              hit   = 1'b1;
              total = total + day_secs[j];
            end
          end
        end
      end
      default: ;
    endcase
    res.total_seconds = 25'(total);
    res.hours_q8      = 21'((64'(total) * 256) / 3600);
    due_totals.push_back(res);
  endfunction

  // compare one accepted result word with the oldest owed result
  function void check_result(logic [24:0] total, logic [20:0] hours);
    on_time_result_t  want;
    if (due_totals.size() == 0) begin
      $error("unexpected result word: total_seconds %0d, hours_q8 %0d", total, hours);
      fails++;
      return;
    end
    want = due_totals.pop_front();
    if (total !== want.total_seconds) begin
      $error("total_seconds: expected %0d, got %0d", want.total_seconds, total);
      fails++;
    end
    if (hours !== want.hours_q8) begin
      $error("hours_q8: expected %0d, got %0d", want.hours_q8, hours);
      fails++;
    end
  endfunction
endclass

module testbench;
  localparam int unsigned DAY        = 86400;
  localparam int unsigned QUIET_MAX  = 20000;  // cycles with no handshake on either side
  localparam int unsigned PHASE_WORDS = 175;
  localparam int unsigned SETTLE     = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // switch_on, now_epoch[31:0], query_day[15:0],
                               // days_count[7:0], zero fill
  logic [1:0]  s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // total_seconds[24:0], hours_q8[20:0], zero fill

  on_time_scoreboard board;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       quiet_cycles;
  bit [31:0]         clock_now;     // epoch of the time-ordered traffic

  daily_on_time_accumulator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random back-pressure, changed on the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // score every result word taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata[24:0], m_axis_tdata[45:25]);
    end
  end

  // watchdog: too long without any word moving means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one command word, with random gaps ahead of it, and wait for the take
  task automatic send_word(cmd_e cmd, bit on, bit [31:0] epoch, bit [15:0] qday,
                           bit [7:0] count);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, count, qday, epoch, on};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(cmd, on, epoch, qday, count);
  endtask

  // hold off the input until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.due_totals.size() != 0) @(posedge clk_i);
  endtask

  // one random word: mostly time-ordered switch and query traffic, some noise
  task automatic random_word();
    int unsigned kind;
    int unsigned spread;
    int unsigned today;
    bit [31:0]   ep;
    kind  = $urandom_range(99);
    today = clock_now / DAY;
    if (kind < 45) begin
      spread = $urandom_range(99);
      if (spread < 70)      ep = clock_now + $urandom_range(0, 20000);
      else if (spread < 90) ep = clock_now + $urandom_range(0, 3 * DAY);
      else if (spread < 97) ep = clock_now + $urandom_range(0, 30 * DAY);
      // step back, never below zero so it cannot wrap into a far jump forward
      else ep = clock_now - $urandom_range(0, (clock_now < 50000) ? clock_now : 50000);
      clock_now = ep;
      send_word(CMD_SWITCH, 1'($urandom), ep, 16'($urandom), 8'($urandom));
    end else if (kind < 75) begin
      send_word(CMD_QUERY, 1'($urandom), $urandom, 16'(today) - 16'($urandom_range(0, 2)),
                ($urandom_range(99) < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom));
    end else if (kind < 85) begin
      clock_now = ($urandom_range(99) < 60) ? $urandom_range(0, 40 * DAY) : $urandom;
      send_word(CMD_BEGIN, 1'($urandom), clock_now, 16'($urandom), 8'($urandom));
    end else if (kind < 92) begin
      send_word(CMD_QUERY, 1'($urandom), $urandom, 16'($urandom), 8'($urandom));
    end else if (kind < 96) begin
      send_word(CMD_IGNORE, 1'($urandom), $urandom, 16'($urandom), 8'($urandom));
    end else begin
      // out-of-order epoch; a far jump forward while on would take ages, so begin instead
      ep        = $urandom;
      clock_now = ep;
      if (board.on_flag && ep > board.prev_epoch && ep - board.prev_epoch > 40 * DAY) begin
        send_word(CMD_BEGIN, 1'($urandom), ep, 16'($urandom), 8'($urandom));
      end else begin
        send_word(CMD_SWITCH, 1'($urandom), ep, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_BEGIN;
    send_idle_pct = 11;
    recv_idle_pct = 86;
    quiet_cycles  = 0;
    clock_now     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed opening ---
    // fresh table: every bucket is day 0 with no seconds
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd0, 8'd1);
    // unknown command with every field at its top value
    send_word(CMD_IGNORE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    // on-interval across the day 0 / day 1 boundary
    send_word(CMD_BEGIN, 1'b0, 32'd100, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b1, 32'd100, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b0, 32'd90100, 16'd0, 8'd0);
    // long look-back runs into day zero, zero-length look-back, days nobody holds
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd1, 8'd255);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd1, 8'd0);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'hFFFF, 8'd255);
    // day 5 counted twice after a step back in time, then a frozen clock: saturates
    send_word(CMD_SWITCH, 1'b1, 5 * DAY + 1000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b1, 5 * DAY + 81000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b1, 5 * DAY + 1000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b1, 5 * DAY + 1000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b0, 5 * DAY + 81000, 16'd0, 8'd0);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd5, 8'd1);
    // last day of the epoch range ends right at the final second
    send_word(CMD_BEGIN, 1'b0, 32'hFFFF_FFFF - 5000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b1, 32'hFFFF_FFFF - 5000, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b0, 32'hFFFF_FFFF, 16'd0, 8'd0);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd49710, 8'd1);
    // begin drops the on flag, so the next switch adds nothing
    send_word(CMD_SWITCH, 1'b1, 10 * DAY + 500, 16'd0, 8'd0);
    send_word(CMD_BEGIN, 1'b0, 10 * DAY + 600, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b0, 12 * DAY, 16'd0, 8'd0);
    // ten days in one interval: older buckets get taken over
    send_word(CMD_SWITCH, 1'b1, 10 * DAY + 500, 16'd0, 8'd0);
    send_word(CMD_SWITCH, 1'b0, 19 * DAY + 100, 16'd0, 8'd0);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd19, 8'd12);
    send_word(CMD_QUERY, 1'b0, 32'd0, 16'd2, 8'd3);
    clock_now = 19 * DAY + 100;
    drain_results();

    // --- random traffic in three throttling phases ---
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 11; recv_idle_pct = 86; end
        1:       begin send_idle_pct = 86; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      repeat (PHASE_WORDS) random_word();
      drain_results();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (board.fails == 0 && board.due_totals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/dota_pkg.sv
src/dota_ram.sv
src/dota_datapath.sv
src/dota_ctrl.sv
src/daily_on_time_accumulator.sv
bench/testbench.sv
